/* design/acdm_pkg.sv */
// shared types and constants for the axis calibrate / deadzone mapper
package acdm_pkg;

  localparam int SAMPLE_BITS = 24;
  // divisor width: raw span or 16-bit output-domain divisors
  localparam int DW          = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  // dividend width: product of a divisor-wide value and a 16-bit constant
  localparam int NW          = (SAMPLE_BITS + 16 > 32) ? SAMPLE_BITS + 16 : 32;
  localparam int QW          = 16;
  localparam int DIV_STAGES  = QW;

  localparam logic [15:0] FULL_SCALE = 16'd65534;
  localparam logic [15:0] MID_SCALE  = 16'd32767;

  typedef enum logic [2:0] {
    CFG_RANGE_MIN  = 3'd0,
    CFG_RANGE_MAX  = 3'd1,
    CFG_DEADZONE   = 3'd2,
    CFG_CENTERED   = 3'd3,
    CFG_WHEEL_MODE = 3'd4,
    CFG_WHEEL_CTR  = 3'd5,
    CFG_WHEEL_HALF = 3'd6
  } cfg_idx_t;

  // sideband that travels with a dividend through a divider
  typedef struct packed {
    logic        forced;
    logic [15:0] fval;
    logic [15:0] add;
  } side_t;

endpackage

/* design/acdm_div.sv */
// pipelined restoring divider, one quotient bit per stage
module acdm_div
  import acdm_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NW-1:0]         num_i,
  input  logic [DW-1:0]         den_i,
  input  side_t                 side_i,
  output logic [QW-1:0]         quo_o,
  output side_t                 side_o
);

  logic [NW-1:0] rem_r  [DIV_STAGES];
  logic [NW-1:0] rem_nxt[DIV_STAGES];
  logic [QW-1:0] quo_r  [DIV_STAGES];
  logic [QW-1:0] quo_nxt[DIV_STAGES];
  logic [DW-1:0] den_r  [DIV_STAGES];
  side_t         side_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    localparam int BP = DIV_STAGES - 1 - k;
    logic [NW-1:0] rem_src;
    logic [QW-1:0] quo_src;
    logic [DW-1:0] den_src;
    side_t         side_src;
    logic [NW-1:0] shd;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_src  = num_i;
      assign quo_src  = '0;
      assign den_src  = den_i;
      assign side_src = side_i;
    end else begin : g_next
      assign rem_src  = rem_r[k-1];
      assign quo_src  = quo_r[k-1];
      assign den_src  = den_r[k-1];
      assign side_src = side_r[k-1];
    end

    assign shd        = NW'(den_src) << BP;
    assign ge         = (rem_src >= shd);
    assign rem_nxt[k] = ge ? (rem_src - shd) : rem_src;
    assign quo_nxt[k] = quo_src | (ge ? (QW'(1) << BP) : QW'(0));

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_src;
        side_r[k] <= side_src;
      end
    end
  end

  assign quo_o  = quo_r[DIV_STAGES-1];
  assign side_o = side_r[DIV_STAGES-1];

endmodule

/* design/axis_calibrate_deadzone_map.sv */
// top level: axis calibration scaling and deadzone, fully pipelined
//
// one raw sample in, one mapped value (0..65534, 32767 is centre) out.
// input channel: in_valid / in_stall / in_raw_sample; a transfer happens on a
// rising edge with valid high and stall low. result channel works the same
// with out_valid / out_stall / out_mapped_value.
// configuration: cfg_we, cfg_index, cfg_data; a write lands on the edge with
// cfg_we high, unknown indexes are dropped. write only while the block is idle.
// throughput: one transfer per cycle while in_stall is low. the work runs
// through 37 register stages: range/offset check, scale multiply, a 16-stage
// divider for the calibration scale, deadzone select, deadzone multiply, a
// second 16-stage divider, and the output register. each stage holds its
// item only while the next stage is full and held, so a stalled receiver
// freezes the output register while bubbles further up keep closing;
// in_stall rises only once every stage holds an item.
// reset (synchronous, active low) empties the pipeline and loads the register
// defaults: range 0..4095, no deadzone, linear floor axis, wheel centre and
// half span zero.
module axis_calibrate_deadzone_map
  import acdm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_raw_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_mapped_value,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [DW-1:0]                 cfg_data
);

  // stage numbering
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_D1  = 2;
  localparam int ST_C1  = ST_D1 + DIV_STAGES;
  localparam int ST_C2  = ST_C1 + 1;
  localparam int ST_D2  = ST_C2 + 1;
  localparam int ST_OUT = ST_D2 + DIV_STAGES;
  localparam int NST    = ST_OUT + 1;

  // configuration registers
  logic signed [SAMPLE_BITS-1:0] range_min_r, range_max_r;
  logic [15:0]                   deadzone_r;
  logic                          centered_r;
  logic                          wheel_r;
  logic [15:0]                   wheel_ctr_r;
  logic [14:0]                   wheel_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r  <= '0;
      range_max_r  <= SAMPLE_BITS'(4095);
      deadzone_r   <= '0;
      centered_r   <= 1'b0;
      wheel_r      <= 1'b0;
      wheel_ctr_r  <= '0;
      wheel_half_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_MIN:  range_min_r  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RANGE_MAX:  range_max_r  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DEADZONE:   deadzone_r   <= cfg_data[15:0];
        CFG_CENTERED:   centered_r   <= cfg_data[0];
        CFG_WHEEL_MODE: wheel_r      <= cfg_data[0];
        CFG_WHEEL_CTR:  wheel_ctr_r  <= cfg_data[15:0];
        CFG_WHEEL_HALF: wheel_half_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // valid bits and bubble-collapsing advance chain
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !adv[ST_A];
  assign out_valid = v_r[ST_OUT];

  // stage a: clamp check and numerator offset, per mode
  logic [DW-1:0]          diff_a_r, diff_a_nxt;
  logic [DW-1:0]          den_a_r, den_a_nxt;
  side_t                  side_a_r, side_a_nxt;
  logic signed [SAMPLE_BITS:0] span, diffl;
  logic [DW-1:0]          raw_z;
  logic [15:0]            wd, twoh;
  logic signed [16:0]     pos;

  always_comb begin
    span  = {range_max_r[SAMPLE_BITS-1], range_max_r}
          - {range_min_r[SAMPLE_BITS-1], range_min_r};
    diffl = {in_raw_sample[SAMPLE_BITS-1], in_raw_sample}
          - {range_min_r[SAMPLE_BITS-1], range_min_r};
    raw_z = DW'(unsigned'(in_raw_sample));
    wd    = raw_z[15:0] - wheel_ctr_r;
    pos   = {wd[15], wd} + {2'b00, wheel_half_r};
    twoh  = {wheel_half_r, 1'b0};

    side_a_nxt = '{forced: 1'b0, fval: 16'd0, add: 16'd0};
    if (wheel_r) begin
      diff_a_nxt = DW'(pos[15:0]);
      den_a_nxt  = DW'(twoh);
      if (pos <= 17'sd0) begin
        side_a_nxt.forced = 1'b1;
      end else if (pos >= $signed({1'b0, twoh})) begin
        side_a_nxt.forced = 1'b1;
        side_a_nxt.fval   = FULL_SCALE;
      end
    end else begin
      diff_a_nxt = DW'(diffl[SAMPLE_BITS-1:0]);
      den_a_nxt  = DW'(span[SAMPLE_BITS-1:0]);
      if (in_raw_sample <= range_min_r) begin
        side_a_nxt.forced = 1'b1;
      end else if (in_raw_sample >= range_max_r) begin
        side_a_nxt.forced = 1'b1;
        side_a_nxt.fval   = FULL_SCALE;
      end else if (span <= 0) begin
        side_a_nxt.forced = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_A]) begin
      diff_a_r <= diff_a_nxt;
      den_a_r  <= den_a_nxt;
      side_a_r <= side_a_nxt;
    end
  end

  // stage b: scale to full range
  logic [NW-1:0] num_b_r;
  logic [DW-1:0] den_b_r;
  side_t         side_b_r;

  always_ff @(posedge clk) begin
    if (adv[ST_B]) begin
      num_b_r  <= NW'(diff_a_r) * NW'(FULL_SCALE);
      den_b_r  <= den_a_r;
      side_b_r <= side_a_r;
    end
  end

  // calibration divider
  logic [QW-1:0] q1;
  side_t         side_d1;

  acdm_div u_div_scale (
    .clk    (clk),
    .en     (adv[ST_D1 +: DIV_STAGES]),
    .num_i  (num_b_r),
    .den_i  (den_b_r),
    .side_i (side_b_r),
    .quo_o  (q1),
    .side_o (side_d1)
  );

  // stage c1: deadzone region select
  logic [15:0] v1, hd, dz_lo, dz_hi;
  logic [15:0] dif_c_r, dif_c_nxt;
  logic [15:0] den_c_r, den_c_nxt;
  logic        mid_c_r, mid_c_nxt;  // multiply by mid scale instead of full
  side_t       side_c_r, side_c_nxt;

  always_comb begin
    v1    = side_d1.forced ? side_d1.fval : q1;
    hd    = {1'b0, deadzone_r[15:1]};
    dz_lo = MID_SCALE - hd;
    dz_hi = MID_SCALE + hd;

    dif_c_nxt  = '0;
    den_c_nxt  = 16'd1;
    mid_c_nxt  = 1'b0;
    side_c_nxt = '{forced: 1'b0, fval: 16'd0, add: 16'd0};
    if (deadzone_r == 16'd0) begin
      side_c_nxt.forced = 1'b1;
      side_c_nxt.fval   = v1;
    end else if (centered_r) begin
      mid_c_nxt = 1'b1;
      if (v1 <= dz_lo) begin
        if (dz_lo == 16'd0) begin
          side_c_nxt.forced = 1'b1;
        end else begin
          dif_c_nxt = v1;
          den_c_nxt = dz_lo;
        end
      end else if (v1 >= dz_hi) begin
        if (dz_hi >= FULL_SCALE) begin
          side_c_nxt.forced = 1'b1;
          side_c_nxt.fval   = FULL_SCALE;
        end else begin
          dif_c_nxt      = v1 - dz_hi;
          den_c_nxt      = FULL_SCALE - dz_hi;
          side_c_nxt.add = MID_SCALE;
        end
      end else begin
        side_c_nxt.forced = 1'b1;
        side_c_nxt.fval   = MID_SCALE;
      end
    end else begin
      if (v1 <= deadzone_r) begin
        side_c_nxt.forced = 1'b1;
      end else begin
        dif_c_nxt = v1 - deadzone_r;
        den_c_nxt = FULL_SCALE - deadzone_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_C1]) begin
      dif_c_r  <= dif_c_nxt;
      den_c_r  <= den_c_nxt;
      mid_c_r  <= mid_c_nxt;
      side_c_r <= side_c_nxt;
    end
  end

  // stage c2: deadzone rescale multiply
  logic [NW-1:0] num_e_r;
  logic [DW-1:0] den_e_r;
  side_t         side_e_r;

  always_ff @(posedge clk) begin
    if (adv[ST_C2]) begin
      num_e_r  <= NW'(dif_c_r) * NW'(mid_c_r ? MID_SCALE : FULL_SCALE);
      den_e_r  <= DW'(den_c_r);
      side_e_r <= side_c_r;
    end
  end

  // deadzone divider
  logic [QW-1:0] q2;
  side_t         side_d2;

  acdm_div u_div_dz (
    .clk    (clk),
    .en     (adv[ST_D2 +: DIV_STAGES]),
    .num_i  (num_e_r),
    .den_i  (den_e_r),
    .side_i (side_e_r),
    .quo_o  (q2),
    .side_o (side_d2)
  );

  // output register
  logic [15:0] out_r;

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_r <= side_d2.forced ? side_d2.fval : (q2 + side_d2.add);
    end
  end

  assign out_mapped_value = out_r;

  // checks
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mapped_value <= FULL_SCALE))
    else $error("mapped value above full scale");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ($countones(v_r) == NST))
    else $error("input held back while a pipeline stage is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_mapped_value)))
    else $error("held result transfer changed");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the axis calibrate / deadzone mapper
module tb
  import acdm_pkg::*;
();

  localparam int LATENCY = 37;
  localparam int CYCLE_LIMIT = 400000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_raw_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [15:0]                   out_mapped_value;
  logic                          cfg_we = 1'b0;
  logic [2:0]                    cfg_index = '0;
  logic [DW-1:0]                 cfg_data = '0;

  // own copy of the register file
  logic signed [SAMPLE_BITS-1:0] m_lo, m_hi;
  logic [15:0]                   m_dz;
  logic                          m_centred, m_wheel;
  logic [15:0]                   m_ctr;
  logic [14:0]                   m_half;

  logic [15:0] expected_values[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // directed stimulus row: sample plus hand-typed value where obvious
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          typed;
    logic [15:0]                   value;
  } dir_row_t;

  axis_calibrate_deadzone_map u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("axis_calibrate_deadzone_map regression: fail");
      $finish;
    end
  end

  // receiver stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0)
        report_mismatch("unexpected transfer", out_mapped_value, 16'd0);
      else begin
        if (out_mapped_value !== expected_values[0])
          report_mismatch("mapped_value", out_mapped_value, expected_values[0]);
        void'(expected_values.pop_front());
      end
    end
  end

  // predicted mapped value for one raw sample under the current registers
  function automatic logic [15:0] mapped_prediction(
      input logic signed [SAMPLE_BITS-1:0] sample);
    longint v, lo, hi, dz, hd, off, half, pos;
    logic [15:0] d;
    if (m_wheel) begin
      d    = sample[15:0] - m_ctr;
      off  = $signed(d);
      half = m_half;
      pos  = off + half;
      if (pos <= 0) v = 0;
      else if (pos >= 2 * half) v = 65534;
      else v = (pos * 65534) / (2 * half);
    end else begin
      lo = m_lo;
      hi = m_hi;
      if (sample <= lo) v = 0;
      else if (sample >= hi) v = 65534;
      else if (hi - lo <= 0) v = 0;
      else v = ((sample - lo) * 65534) / (hi - lo);
    end
    dz = m_dz;
    if (dz > 0) begin
      if (m_centred) begin
        hd = dz / 2;
        lo = 32767 - hd;
        hi = 32767 + hd;
        if (v <= lo) v = (lo <= 0) ? 0 : (v * 32767) / lo;
        else if (v >= hi)
          v = (hi >= 65534) ? 65534 : 32767 + ((v - hi) * 32767) / (65534 - hi);
        else v = 32767;
      end else if (v <= dz) v = 0;
      else v = ((v - dz) * 65534) / (65534 - dz);
    end
    return v[15:0];
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_RANGE_MIN:  m_lo      = data[SAMPLE_BITS-1:0];
      CFG_RANGE_MAX:  m_hi      = data[SAMPLE_BITS-1:0];
      CFG_DEADZONE:   m_dz      = data[15:0];
      CFG_CENTERED:   m_centred = data[0];
      CFG_WHEEL_MODE: m_wheel   = data[0];
      CFG_WHEEL_CTR:  m_ctr     = data[15:0];
      CFG_WHEEL_HALF: m_half    = data[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one input transfer, with a random gap before it
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= sample;
    do @(posedge clk); while (in_stall);
    expected_values.push_back(mapped_prediction(sample));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // random sample, biased to the calibrated range or the wheel window
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    int sel;
    sel = $urandom_range(9);
    s = SAMPLE_BITS'($urandom);
    if (sel < 6) begin
      if (m_wheel)
        s[15:0] = m_ctr + 16'($signed($urandom_range(2 * m_half + 40)) - m_half - 20);
      else if (m_hi > m_lo)
        s = m_lo + $signed(24'($urandom_range(32'(m_hi - m_lo))));
    end else if (sel == 6) s = m_lo;
    else if (sel == 7) s = m_hi;
    return s;
  endfunction

  task automatic random_setting(input int phase);
    logic signed [SAMPLE_BITS-1:0] a, b;
    int k;
    k = $urandom_range(9);
    a = SAMPLE_BITS'($urandom);
    b = SAMPLE_BITS'($urandom);
    if (k < 5) begin
      a = $signed(24'($urandom_range(8000))) - 24'sd4000;
      b = a + $signed(24'($urandom_range(70000)));
    end
    write_reg(CFG_RANGE_MIN, DW'(a));
    write_reg(CFG_RANGE_MAX, DW'(b));
    case ($urandom_range(5))
      0: write_reg(CFG_DEADZONE, DW'(0));
      1: write_reg(CFG_DEADZONE, DW'(65535 - $urandom_range(3)));
      default: write_reg(CFG_DEADZONE, DW'($urandom_range(20000)));
    endcase
    write_reg(CFG_CENTERED, DW'($urandom_range(1)));
    write_reg(CFG_WHEEL_MODE, DW'(phase % 2));
    write_reg(CFG_WHEEL_CTR, DW'($urandom_range(65535)));
    case ($urandom_range(4))
      0: write_reg(CFG_WHEEL_HALF, DW'(0));
      1: write_reg(CFG_WHEEL_HALF, DW'(32767));
      default: write_reg(CFG_WHEEL_HALF, DW'($urandom_range(2000)));
    endcase
  endtask

  dir_row_t dir_rows[$];

  initial begin
    m_lo = 0; m_hi = 4095; m_dz = 0; m_centred = 0; m_wheel = 0; m_ctr = 0;
    m_half = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: linear 0..4095, no deadzone
    dir_rows = '{
      '{24'sd0, 1'b1, 16'd0}, '{24'sd4095, 1'b1, 16'd65534},
      '{-24'sd8388608, 1'b1, 16'd0}, '{24'sd8388607, 1'b1, 16'd65534},
      '{24'sd2048, 1'b0, 16'd0}, '{24'sd1, 1'b0, 16'd0}, '{24'sd4094, 1'b0, 16'd0}};
    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].sample);
      if (dir_rows[i].typed && expected_values[$] !== dir_rows[i].value)
        report_mismatch("directed prediction", expected_values[$],
                        dir_rows[i].value);
    end
    drain();

    // inverted range, full-width extremes
    write_reg(CFG_RANGE_MIN, DW'(24'sd8388607));
    write_reg(CFG_RANGE_MAX, DW'(-24'sd8388608));
    send_sample(24'sd8388607);
    send_sample(-24'sd8388608);
    send_sample(24'sd0);
    drain();
    write_reg(CFG_RANGE_MIN, DW'(-24'sd8388608));
    write_reg(CFG_RANGE_MAX, DW'(24'sd8388607));
    send_sample(24'sd0);
    send_sample(24'sd8388606);
    drain();
    // oversized centre deadzone, then floor deadzones
    write_reg(CFG_DEADZONE, DW'(16'hFFFF));
    write_reg(CFG_CENTERED, DW'(1));
    send_sample(-24'sd8388608);
    send_sample(24'sd8388607);
    send_sample(24'sd5);
    drain();
    write_reg(CFG_CENTERED, DW'(0));
    write_reg(CFG_DEADZONE, DW'(16'd65534));
    send_sample(24'sd8388607);
    drain();
    write_reg(CFG_DEADZONE, DW'(16'd1000));
    send_sample(24'sd3);
    send_sample(24'sd100000);
    drain();
    // wheel with zero half span, then a full half span
    write_reg(CFG_DEADZONE, DW'(0));
    write_reg(CFG_WHEEL_MODE, DW'(1));
    write_reg(CFG_WHEEL_CTR, DW'(16'hFFFF));
    send_sample(24'h00FFFF);
    send_sample(24'h000000);
    send_sample(24'h00FFFE);
    drain();
    write_reg(CFG_WHEEL_HALF, DW'(15'h7FFF));
    send_sample(24'hFF7FFF);
    send_sample(24'h007FFF);
    send_sample(24'h001234);
    drain();

    // random phases; the idle split changes by third
    for (int phase = 0; phase < 30; phase++) begin
      send_idle_pct = (phase < 10) ? 27 : (phase < 20) ? 50 : 0;
      recv_idle_pct = (phase < 10) ? 50 : (phase < 20) ? 27 : 0;
      random_setting(phase);
      for (int n = 0; n < 60; n++) begin
        // sender holds off until the pipeline has emptied
        if (n == 30 && phase % 7 == 3) begin
          in_valid <= 1'b0;
          while (expected_values.size() != 0) @(posedge clk);
        end
        send_sample(random_sample());
      end
      drain();
    end

    if (fail_count == 0) $display("axis_calibrate_deadzone_map regression: pass");
    else $display("axis_calibrate_deadzone_map regression: fail");
    $finish;
  end

endmodule

/* files.f */
design/acdm_pkg.sv
design/acdm_div.sv
design/axis_calibrate_deadzone_map.sv
test/tb.sv
